>>> design/bts_pkg.sv
// shared constants and types for the bilinear texture sampler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package bts_pkg;
	localparam int MAX_SIDE_DEF   = 256;
	localparam int COORD_FRAC_DEF = 16;
	localparam int CFG_W          = 9;
	localparam int CFG_IDX_W      = 8;
	localparam int CHAN_W         = 16;
	localparam int TEXEL_W        = 32;
	localparam int ADDR_IN_W      = 16;
	localparam int SIDE_RESET     = 256;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 8'd1;

	localparam int POS_RED   = 16;
	localparam int POS_GREEN = 8;
	localparam int POS_BLUE  = 0;
	localparam int POS_ALPHA = 24;

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

	typedef struct packed {
		logic sample;
		logic write;
	} ctl_t;
endpackage
`default_nettype wire

>>> design/bts_mem.sv
// one copy of the texel store, one write and one registered read port
// uses bts_pkg
`timescale 1ns / 1ps
`default_nettype none
module bts_mem #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [AW-1:0]               waddr,
	input  wire logic [bts_pkg::TEXEL_W-1:0] wdata,
	input  wire logic [AW-1:0]               raddr,
	output logic      [bts_pkg::TEXEL_W-1:0] rdata
);
	import bts_pkg::*;

	logic [TEXEL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> design/bts_addr.sv
// coordinate scaling and neighbour address generation, stages s1 and s2
// uses bts_pkg
`timescale 1ns / 1ps
`default_nettype none
module bts_addr #(
	parameter int SW    = 9,
	parameter int AW    = 16,
	parameter int F     = 16,
	parameter int DEPTH = 65536
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire logic                          op,
	input  wire logic [bts_pkg::ADDR_IN_W-1:0] texel_address,
	input  wire logic [bts_pkg::TEXEL_W-1:0]   texel_value,
	input  wire logic [F:0]                    u,
	input  wire logic [F:0]                    v,
	input  wire logic                          bilinear,
	input  wire logic [SW-1:0]                 w,
	input  wire logic [SW-1:0]                 h,
	output bts_pkg::ctl_t                      ctl_s2,
	output logic [AW-1:0]                      waddr_s2,
	output logic [bts_pkg::TEXEL_W-1:0]        wdata_s2,
	output logic [AW-1:0]                      a00_s2,
	output logic [AW-1:0]                      a10_s2,
	output logic [AW-1:0]                      a01_s2,
	output logic [AW-1:0]                      a11_s2,
	output logic [F-1:0]                       fx_s2,
	output logic [F-1:0]                       fy_s2
);
	import bts_pkg::*;

	localparam logic [F:0] ONE = (F+1)'(1) << F;

	logic [F:0]      cu, cv;
	logic [F+SW:0]   su, sv;
	logic            wr_ok;
	ctl_t            ctl_s1;
	logic [AW-1:0]   waddr_s1;
	logic [TEXEL_W-1:0] wdata_s1;
	logic [SW-1:0]   x_s1, y_s1;
	logic [F-1:0]    fx_s1, fy_s1;
	logic [2*SW-1:0] base;

	assign cu    = (u > ONE) ? ONE : u;
	assign cv    = (v > ONE) ? ONE : v;
	assign su    = (F+SW+1)'(cu) * (F+SW+1)'(w - SW'(2));
	assign sv    = (F+SW+1)'(cv) * (F+SW+1)'(h - SW'(2));
	assign wr_ok = 32'(texel_address) < 32'(DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1.sample <= accept && (op == OP_SAMPLE);
			ctl_s1.write  <= accept && (op == OP_WRITE) && wr_ok;
			ctl_s2        <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		waddr_s1 <= AW'(texel_address);
		wdata_s1 <= texel_value;
		x_s1     <= su[F +: SW];
		y_s1     <= sv[F +: SW];
		fx_s1    <= bilinear ? su[F-1:0] : '0;
		fy_s1    <= bilinear ? sv[F-1:0] : '0;
	end

	assign base = (2*SW)'(y_s1) * (2*SW)'(w) + (2*SW)'(x_s1);

	always_ff @(posedge clk) begin
		waddr_s2 <= waddr_s1;
		wdata_s2 <= wdata_s1;
		a00_s2   <= AW'(base);
		a10_s2   <= AW'(base + (2*SW)'(1));
		a01_s2   <= AW'(base + (2*SW)'(w));
		a11_s2   <= AW'(base + (2*SW)'(w) + (2*SW)'(1));
		fx_s2    <= fx_s1;
		fy_s2    <= fy_s1;
	end
endmodule
`default_nettype wire

>>> design/bts_filter.sv
// horizontal then vertical blend of the four fetched texels, stages s3 to s5
// uses bts_pkg
`timescale 1ns / 1ps
`default_nettype none
module bts_filter #(
	parameter int F = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        sample_s2,
	input  wire logic [F-1:0]                fx_s2,
	input  wire logic [F-1:0]                fy_s2,
	input  wire logic [bts_pkg::TEXEL_W-1:0] t00,
	input  wire logic [bts_pkg::TEXEL_W-1:0] t10,
	input  wire logic [bts_pkg::TEXEL_W-1:0] t01,
	input  wire logic [bts_pkg::TEXEL_W-1:0] t11,
	output logic                             out_valid,
	output logic [bts_pkg::CHAN_W-1:0]       red,
	output logic [bts_pkg::CHAN_W-1:0]       green,
	output logic [bts_pkg::CHAN_W-1:0]       blue,
	output logic [bts_pkg::CHAN_W-1:0]       alpha
);
	import bts_pkg::*;

	localparam int PW = CHAN_W + F + 2;
	localparam logic [F:0] ONE = (F+1)'(1) << F;
	localparam int POS [4] = '{POS_RED, POS_GREEN, POS_BLUE, POS_ALPHA};

	logic              sample_s3, sample_s4;
	logic [F-1:0]      fx_s3, fy_s3, fy_s4;
	logic [CHAN_W-1:0] top_s4 [4];
	logic [CHAN_W-1:0] bot_s4 [4];
	logic [CHAN_W-1:0] top_c [4];
	logic [CHAN_W-1:0] bot_c [4];
	logic [CHAN_W-1:0] res_c [4];
	logic [PW-1:0]     st [4];
	logic [PW-1:0]     sb [4];
	logic [PW-1:0]     sv [4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			st[k] = PW'({t00[POS[k] +: 8], 8'h00}) * PW'(ONE - (F+1)'(fx_s3))
			      + PW'({t10[POS[k] +: 8], 8'h00}) * PW'(fx_s3);
			sb[k] = PW'({t01[POS[k] +: 8], 8'h00}) * PW'(ONE - (F+1)'(fx_s3))
			      + PW'({t11[POS[k] +: 8], 8'h00}) * PW'(fx_s3);
			top_c[k] = st[k][F +: CHAN_W];
			bot_c[k] = sb[k][F +: CHAN_W];
			sv[k] = PW'(top_s4[k]) * PW'(ONE - (F+1)'(fy_s4))
			      + PW'(bot_s4[k]) * PW'(fy_s4);
			res_c[k] = sv[k][F +: CHAN_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_s3 <= 1'b0;
			sample_s4 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			sample_s3 <= sample_s2;
			sample_s4 <= sample_s3;
			out_valid <= sample_s4;
		end
	end

	always_ff @(posedge clk) begin
		fx_s3 <= fx_s2;
		fy_s3 <= fy_s2;
		fy_s4 <= fy_s3;
		top_s4 <= top_c;
		bot_s4 <= bot_c;
		red   <= res_c[0];
		green <= res_c[1];
		blue  <= res_c[2];
		alpha <= res_c[3];
	end
endmodule
`default_nettype wire

>>> design/bilinear_texture_sampler.sv
// top level of the bilinear texture sampler: config registers, four store copies
// uses bts_pkg, bts_addr, bts_mem, bts_filter
`timescale 1ns / 1ps
`default_nettype none
// Takes one item per clock: busy is always low. A write item stores one texel;
// a sample item gives one result on red, green, blue and alpha, strobed by
// out_valid once it has passed stages s1 to s5. The receiver cannot
// stall. The store is held in four copies that every write updates, so the
// four neighbours of a sample are read in the same cycle, one read port per copy.
// Configuration writes are always ready and take effect at once.
module bilinear_texture_sampler #(
	parameter int MAX_SIDE        = bts_pkg::MAX_SIDE_DEF,
	parameter int COORD_FRAC_BITS = bts_pkg::COORD_FRAC_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          op,
	input  wire logic [bts_pkg::ADDR_IN_W-1:0] texel_address,
	input  wire logic [bts_pkg::TEXEL_W-1:0]   texel_value,
	input  wire logic [COORD_FRAC_BITS:0]      u,
	input  wire logic [COORD_FRAC_BITS:0]      v,
	input  wire logic                          bilinear,
	output logic                               out_valid,
	output logic [bts_pkg::CHAN_W-1:0]         red,
	output logic [bts_pkg::CHAN_W-1:0]         green,
	output logic [bts_pkg::CHAN_W-1:0]         blue,
	output logic [bts_pkg::CHAN_W-1:0]         alpha,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [bts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bts_pkg::CFG_W-1:0]     cfg_data
);
	import bts_pkg::*;

	localparam int SW    = $clog2(MAX_SIDE + 1);
	localparam int AW    = 2 * $clog2(MAX_SIDE);
	localparam int DEPTH = MAX_SIDE * MAX_SIDE;

	logic [CFG_W-1:0]   width_q, height_q;
	logic [SW-1:0]      w_c, h_c;
	ctl_t               ctl_s2;
	logic [AW-1:0]      waddr_s2, a00_s2, a10_s2, a01_s2, a11_s2;
	logic [TEXEL_W-1:0] wdata_s2, t00, t10, t01, t11;
	logic [COORD_FRAC_BITS-1:0] fx_s2, fy_s2;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(SIDE_RESET);
			height_q <= CFG_W'(SIDE_RESET);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_WIDTH) begin
				width_q <= cfg_data;
			end else if (cfg_index == REG_HEIGHT) begin
				height_q <= cfg_data;
			end
		end
	end

	// saturate sizes to two .. max side
	always_comb begin
		if (32'(width_q) < 32'd2) w_c = SW'(2);
		else if (32'(width_q) > 32'(MAX_SIDE)) w_c = SW'(MAX_SIDE);
		else w_c = SW'(width_q);
		if (32'(height_q) < 32'd2) h_c = SW'(2);
		else if (32'(height_q) > 32'(MAX_SIDE)) h_c = SW'(MAX_SIDE);
		else h_c = SW'(height_q);
	end

	bts_addr #(.SW(SW), .AW(AW), .F(COORD_FRAC_BITS), .DEPTH(DEPTH)) u_addr (
		.clk(clk), .arst_n(arst_n), .accept(start && !busy), .op(op),
		.texel_address(texel_address), .texel_value(texel_value),
		.u(u), .v(v), .bilinear(bilinear), .w(w_c), .h(h_c),
		.ctl_s2(ctl_s2), .waddr_s2(waddr_s2), .wdata_s2(wdata_s2),
		.a00_s2(a00_s2), .a10_s2(a10_s2), .a01_s2(a01_s2), .a11_s2(a11_s2),
		.fx_s2(fx_s2), .fy_s2(fy_s2)
	);

	bts_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem00 (
		.clk(clk), .we(ctl_s2.write), .waddr(waddr_s2), .wdata(wdata_s2),
		.raddr(a00_s2), .rdata(t00)
	);
	bts_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem10 (
		.clk(clk), .we(ctl_s2.write), .waddr(waddr_s2), .wdata(wdata_s2),
		.raddr(a10_s2), .rdata(t10)
	);
	bts_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem01 (
		.clk(clk), .we(ctl_s2.write), .waddr(waddr_s2), .wdata(wdata_s2),
		.raddr(a01_s2), .rdata(t01)
	);
	bts_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem11 (
		.clk(clk), .we(ctl_s2.write), .waddr(waddr_s2), .wdata(wdata_s2),
		.raddr(a11_s2), .rdata(t11)
	);

	bts_filter #(.F(COORD_FRAC_BITS)) u_filter (
		.clk(clk), .arst_n(arst_n), .sample_s2(ctl_s2.sample),
		.fx_s2(fx_s2), .fy_s2(fy_s2),
		.t00(t00), .t10(t10), .t01(t01), .t11(t11),
		.out_valid(out_valid), .red(red), .green(green), .blue(blue), .alpha(alpha)
	);
endmodule
`default_nettype wire

>>> design/bts_checker.sv
// port-level checks for the bilinear texture sampler, bound to the top level
// uses bts_pkg
`timescale 1ns / 1ps
`default_nettype none
module bts_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        start,
	input wire logic                        busy,
	input wire logic                        op,
	input wire logic                        bilinear,
	input wire logic                        out_valid,
	input wire logic [bts_pkg::CHAN_W-1:0]  red,
	input wire logic [bts_pkg::CHAN_W-1:0]  alpha
);
	import bts_pkg::*;

	a_sample_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (op == OP_SAMPLE) |-> ##5 out_valid)
		else $error("sample item gave no result");

	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (op == OP_WRITE) |-> ##5 !out_valid)
		else $error("write item gave a result");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##5 !out_valid)
		else $error("result without item");

	a_point_whole: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (op == OP_SAMPLE) && !bilinear |-> ##5
		(red[7:0] == 8'h00) && (alpha[7:0] == 8'h00))
		else $error("point sample has a fraction");
endmodule

bind bilinear_texture_sampler bts_checker u_bts_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
	.bilinear(bilinear), .out_valid(out_valid), .red(red), .alpha(alpha)
);
`default_nettype wire
